FILE: src/vec3_vector_alu_defines.svh
// assertion macros for the vec3 vector unit
// used by vec3_vector_alu.sv, needs clk and arst_n in scope
`ifndef VEC3_VECTOR_ALU_DEFINES_SVH
`define VEC3_VECTOR_ALU_DEFINES_SVH

// plain property on every clock edge out of reset
`define VVA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication on every clock edge out of reset
`define VVA_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: src/vva_pkg.sv
// shared types, constants and helpers of the vec3 vector unit
// no dependencies
package vva_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int NUM_W       = 32 + FRAC_BITS;
	localparam int RAD_W       = 64;
	localparam int SQRT_STAGES = RAD_W / 2;
	localparam int DIV_STAGES  = 32;
	localparam int DIV_LAT     = DIV_STAGES + 2;
	localparam int LATENCY     = 3 + SQRT_STAGES + DIV_LAT + 2;

	typedef enum logic [2:0] {
		OP_DOT   = 3'd0,
		OP_CROSS = 3'd1,
		OP_PROJ  = 3'd2,
		OP_PERP  = 3'd3,
		OP_LEN   = 3'd4,
		OP_NORM  = 3'd5,
		OP_TEST  = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIVZ = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	typedef struct packed {
		logic [31:0] val;
		logic        ovf;
	} sat_t;

	typedef struct packed {
		logic [31:0] val;
		logic        sat;
	} div_res_t;

	// item context that rides alongside the arithmetic
	typedef struct packed {
		op_t              op;
		logic [2:0][31:0] a;
		logic [2:0][31:0] b;
		logic [2:0][31:0] r;
		logic [31:0]      d;
		logic [31:0]      e;
		logic             test;
		logic             ovf;
		logic             divz;
	} sb_t;

	function automatic logic signed [65:0] sx66(input logic signed [63:0] p);
		sx66 = {{2{p[63]}}, p};
	endfunction

	// clamp to the signed 32-bit range
	function automatic sat_t sat32(input logic signed [65:0] v);
		sat_t s;
		if ((&v[65:31]) || !(|v[65:31])) begin
			s.val = v[31:0];
			s.ovf = 1'b0;
		end else begin
			s.val = v[65] ? 32'h8000_0000 : 32'h7fff_ffff;
			s.ovf = 1'b1;
		end
		return s;
	endfunction

endpackage

FILE: src/vva_sqrt.sv
// pipelined integer square root, two radicand bits per stage
// depends on vva_pkg
module vva_sqrt (
	input  logic                       clk,
	input  logic [vva_pkg::RAD_W-1:0]  rad,
	output logic [vva_pkg::RAD_W/2-1:0] root
);

	logic [vva_pkg::RAD_W-1:0] rem_s [0:vva_pkg::SQRT_STAGES-1];
	logic [vva_pkg::RAD_W-1:0] res_s [0:vva_pkg::SQRT_STAGES-1];

	for (genvar k = 0; k < vva_pkg::SQRT_STAGES; k++) begin : g_st
		logic [vva_pkg::RAD_W-1:0] rem_i, res_i, bitv, trial;
		if (k == 0) begin : g_first
			assign rem_i = rad;
			assign res_i = '0;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign res_i = res_s[k-1];
		end
		assign bitv  = {{(vva_pkg::RAD_W-1){1'b0}}, 1'b1} << (vva_pkg::RAD_W - 2 - 2*k);
		assign trial = res_i + bitv;
		always_ff @(posedge clk) begin
			if (rem_i >= trial) begin
				rem_s[k] <= rem_i - trial;
				res_s[k] <= (res_i >> 1) + bitv;
			end else begin
				rem_s[k] <= rem_i;
				res_s[k] <= res_i >> 1;
			end
		end
	end

	assign root = res_s[vva_pkg::SQRT_STAGES-1][vva_pkg::RAD_W/2-1:0];

endmodule

FILE: src/vva_div.sv
// pipelined signed by unsigned divider, truncating, saturated to 32 bits
// depends on vva_pkg
module vva_div (
	input  logic                              clk,
	input  logic signed [vva_pkg::NUM_W-1:0]  num,
	input  logic [31:0]                       den,
	output vva_pkg::div_res_t                 res
);

	localparam int N = vva_pkg::DIV_STAGES;

	logic [31:0] rem_s [0:N];
	logic [31:0] rq_s  [0:N];
	logic [31:0] den_s [0:N];
	logic        neg_s [0:N];
	logic        big_s [0:N];

	logic [vva_pkg::NUM_W-1:0] mag;
	logic [31:0]               hi;

	always_comb begin
		mag = num[vva_pkg::NUM_W-1] ? (~num + 1'b1) : num;
		hi  = 32'(mag[vva_pkg::NUM_W-1:32]);
	end

	// prep: magnitude, sign and an early quotient overflow check
	always_ff @(posedge clk) begin
		neg_s[0] <= num[vva_pkg::NUM_W-1];
		big_s[0] <= hi >= den;
		rem_s[0] <= hi;
		rq_s[0]  <= mag[31:0];
		den_s[0] <= den;
	end

	for (genvar k = 1; k <= N; k++) begin : g_st
		logic [32:0] trial, diff;
		logic        ge;
		assign trial = {rem_s[k-1], rq_s[k-1][31]};
		assign ge    = trial >= {1'b0, den_s[k-1]};
		assign diff  = trial - {1'b0, den_s[k-1]};
		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? diff[31:0] : trial[31:0];
			rq_s[k]  <= {rq_s[k-1][30:0], ge};
			den_s[k] <= den_s[k-1];
			neg_s[k] <= neg_s[k-1];
			big_s[k] <= big_s[k-1];
		end
	end

	logic [31:0] q;
	logic        q_sat;

	always_comb begin
		q = rq_s[N];
		if (neg_s[N])
			q_sat = big_s[N] || (q[31] && (|q[30:0]));
		else
			q_sat = big_s[N] || q[31];
	end

	always_ff @(posedge clk) begin
		res.sat <= q_sat;
		if (q_sat)
			res.val <= neg_s[N] ? 32'h8000_0000 : 32'h7fff_ffff;
		else
			res.val <= neg_s[N] ? (~q + 1'b1) : q;
	end

endmodule

FILE: src/vec3_vector_alu.sv
// three-component fixed-point vector unit, top level
// depends on vva_pkg, vva_sqrt, vva_div and vec3_vector_alu_defines.svh
// throughput: one request per cycle, busy never rises and done strobes once per request
// the latency comes mostly from the 32-stage square root followed by the 34-stage divider lanes
// reset clears only the valid bits, so no result strobes after reset until a new request
`include "vec3_vector_alu_defines.svh"

module vec3_vector_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         opcode,
	input  logic signed [31:0] ax,
	input  logic signed [31:0] ay,
	input  logic signed [31:0] az,
	input  logic signed [31:0] bx,
	input  logic signed [31:0] by,
	input  logic signed [31:0] bz,
	output logic               done,
	output logic signed [31:0] rx,
	output logic signed [31:0] ry,
	output logic signed [31:0] rz,
	output logic               test_true,
	output logic [1:0]         status
);

	localparam int F  = vva_pkg::FRAC_BITS;
	localparam int NS = vva_pkg::SQRT_STAGES;
	localparam int ND = vva_pkg::DIV_LAT;

	// fully pipelined, never stalls
	assign busy = 1'b0;

	// ------------------------------------------------------------------
	// stage 1: operand routing into six multipliers
	// ------------------------------------------------------------------
	vva_pkg::op_t       op_in;
	logic signed [31:0] mul_a [0:5];
	logic signed [31:0] mul_b [0:5];

	always_comb begin
		op_in = vva_pkg::op_t'(opcode);
		for (int i = 0; i < 6; i++) begin
			mul_a[i] = '0;
			mul_b[i] = '0;
		end
		case (op_in)
			vva_pkg::OP_DOT, vva_pkg::OP_TEST: begin
				mul_a[0] = ax; mul_b[0] = bx;
				mul_a[1] = ay; mul_b[1] = by;
				mul_a[2] = az; mul_b[2] = bz;
			end
			vva_pkg::OP_CROSS: begin
				// pairs that are subtracted: x, y and z components
				mul_a[0] = ay; mul_b[0] = bz;
				mul_a[1] = az; mul_b[1] = by;
				mul_a[2] = az; mul_b[2] = bx;
				mul_a[3] = ax; mul_b[3] = bz;
				mul_a[4] = ax; mul_b[4] = by;
				mul_a[5] = ay; mul_b[5] = bx;
			end
			vva_pkg::OP_PROJ, vva_pkg::OP_PERP: begin
				// a.b on the first three, b.b on the last three
				mul_a[0] = ax; mul_b[0] = bx;
				mul_a[1] = ay; mul_b[1] = by;
				mul_a[2] = az; mul_b[2] = bz;
				mul_a[3] = bx; mul_b[3] = bx;
				mul_a[4] = by; mul_b[4] = by;
				mul_a[5] = bz; mul_b[5] = bz;
			end
			vva_pkg::OP_LEN, vva_pkg::OP_NORM: begin
				mul_a[0] = ax; mul_b[0] = ax;
				mul_a[1] = ay; mul_b[1] = ay;
				mul_a[2] = az; mul_b[2] = az;
			end
			default: begin
			end
		endcase
	end

	logic               v_s1;
	vva_pkg::op_t       op_s1;
	logic [2:0][31:0]   a_s1, b_s1;
	logic signed [63:0] p_s1 [0:5];

	always_ff @(posedge clk) begin
		op_s1 <= op_in;
		a_s1  <= {az, ay, ax};
		b_s1  <= {bz, by, bx};
		for (int i = 0; i < 6; i++)
			p_s1[i] <= mul_a[i] * mul_b[i];
	end

	// ------------------------------------------------------------------
	// stage 2: exact sums and differences of the products
	// ------------------------------------------------------------------
	logic               v_s2;
	vva_pkg::op_t       op_s2;
	logic [2:0][31:0]   a_s2, b_s2;
	logic signed [65:0] sum_s2 [0:2];

	always_ff @(posedge clk) begin
		op_s2 <= op_s1;
		a_s2  <= a_s1;
		b_s2  <= b_s1;
		if (op_s1 == vva_pkg::OP_CROSS) begin
			sum_s2[0] <= vva_pkg::sx66(p_s1[0]) - vva_pkg::sx66(p_s1[1]);
			sum_s2[1] <= vva_pkg::sx66(p_s1[2]) - vva_pkg::sx66(p_s1[3]);
			sum_s2[2] <= vva_pkg::sx66(p_s1[4]) - vva_pkg::sx66(p_s1[5]);
		end else begin
			sum_s2[0] <= vva_pkg::sx66(p_s1[0]) + vva_pkg::sx66(p_s1[1])
				+ vva_pkg::sx66(p_s1[2]);
			sum_s2[1] <= vva_pkg::sx66(p_s1[3]) + vva_pkg::sx66(p_s1[4])
				+ vva_pkg::sx66(p_s1[5]);
			sum_s2[2] <= '0;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: single rounding toward minus infinity, then clamping
	// ------------------------------------------------------------------
	vva_pkg::sat_t f [0:2];
	vva_pkg::sb_t  sb_n3;

	always_comb begin
		for (int i = 0; i < 3; i++)
			f[i] = vva_pkg::sat32(sum_s2[i] >>> F);
		sb_n3      = '0;
		sb_n3.op   = op_s2;
		sb_n3.a    = a_s2;
		sb_n3.b    = b_s2;
		case (op_s2)
			vva_pkg::OP_DOT: begin
				sb_n3.r[0] = f[0].val;
				sb_n3.ovf  = f[0].ovf;
			end
			vva_pkg::OP_CROSS: begin
				sb_n3.r[0] = f[0].val;
				sb_n3.r[1] = f[1].val;
				sb_n3.r[2] = f[2].val;
				sb_n3.ovf  = f[0].ovf | f[1].ovf | f[2].ovf;
			end
			vva_pkg::OP_PROJ, vva_pkg::OP_PERP: begin
				// b.b is never negative, so only zero is a bad divisor
				sb_n3.d    = f[0].val;
				sb_n3.e    = f[1].val;
				sb_n3.ovf  = f[0].ovf | f[1].ovf;
				sb_n3.divz = f[1].val == '0;
			end
			vva_pkg::OP_TEST: begin
				sb_n3.test = sum_s2[0] == '0;
			end
			default: begin
			end
		endcase
	end

	logic                      v_s3;
	vva_pkg::sb_t              sb_s3;
	logic [vva_pkg::RAD_W-1:0] rad_s3;

	always_ff @(posedge clk) begin
		sb_s3  <= sb_n3;
		// sum of squares is non-negative and fits the radicand
		rad_s3 <= sum_s2[0][vva_pkg::RAD_W-1:0];
	end

	// ------------------------------------------------------------------
	// square root, with the item context delayed alongside
	// ------------------------------------------------------------------
	logic [vva_pkg::RAD_W/2-1:0] root;

	vva_sqrt u_sqrt (
		.clk  (clk),
		.rad  (rad_s3),
		.root (root)
	);

	vva_pkg::sb_t sb1_s [0:NS-1];
	logic         v1_s  [0:NS-1];

	always_ff @(posedge clk) begin
		sb1_s[0] <= sb_s3;
		for (int k = 1; k < NS; k++)
			sb1_s[k] <= sb1_s[k-1];
	end

	// length result and divider operand selection
	vva_pkg::sb_t              sb_np;
	logic signed [vva_pkg::NUM_W-1:0] num_p [0:2];
	logic [31:0]               den_p;

	always_comb begin
		sb_np = sb1_s[NS-1];
		for (int i = 0; i < 3; i++)
			num_p[i] = $signed({sb_np.a[i], {F{1'b0}}});
		den_p = root;
		case (sb_np.op)
			vva_pkg::OP_LEN: begin
				sb_np.r[0] = root[31] ? 32'h7fff_ffff : root;
				sb_np.ovf  = root[31];
			end
			vva_pkg::OP_NORM: begin
				sb_np.divz = root == '0;
			end
			vva_pkg::OP_PROJ, vva_pkg::OP_PERP: begin
				num_p[0] = $signed({sb_np.d, {F{1'b0}}});
				den_p    = sb_np.e;
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// three divider lanes: lane 0 also serves the projection scale
	// ------------------------------------------------------------------
	vva_pkg::div_res_t dq [0:2];

	for (genvar i = 0; i < 3; i++) begin : g_div
		vva_div u_div (
			.clk (clk),
			.num (num_p[i]),
			.den (den_p),
			.res (dq[i])
		);
	end

	vva_pkg::sb_t sb2_s [0:ND-1];
	logic         v2_s  [0:ND-1];

	always_ff @(posedge clk) begin
		sb2_s[0] <= sb_np;
		for (int k = 1; k < ND; k++)
			sb2_s[k] <= sb2_s[k-1];
	end

	// ------------------------------------------------------------------
	// projection multiply: b scaled by the quotient
	// ------------------------------------------------------------------
	vva_pkg::sb_t sb_nm;

	always_comb begin
		sb_nm = sb2_s[ND-1];
		case (sb_nm.op)
			vva_pkg::OP_PROJ, vva_pkg::OP_PERP: begin
				sb_nm.ovf = sb_nm.ovf | dq[0].sat;
			end
			vva_pkg::OP_NORM: begin
				for (int i = 0; i < 3; i++)
					sb_nm.r[i] = dq[i].val;
				sb_nm.ovf = sb_nm.ovf | dq[0].sat | dq[1].sat | dq[2].sat;
			end
			default: begin
			end
		endcase
	end

	logic               v_m_q;
	vva_pkg::sb_t       sb_m_q;
	logic signed [63:0] prod_m_q [0:2];

	always_ff @(posedge clk) begin
		sb_m_q <= sb_nm;
		for (int i = 0; i < 3; i++)
			prod_m_q[i] <= $signed(sb2_s[ND-1].b[i]) * $signed(dq[0].val);
	end

	// ------------------------------------------------------------------
	// final rounding, perpendicular part and result select
	// ------------------------------------------------------------------
	vva_pkg::sat_t      pr   [0:2];
	vva_pkg::sat_t      dsat [0:2];
	logic signed [32:0] diff [0:2];
	logic [2:0][31:0]   r_f;
	logic               ovf_f;

	always_comb begin
		r_f   = sb_m_q.r;
		ovf_f = sb_m_q.ovf;
		for (int i = 0; i < 3; i++) begin
			pr[i]   = vva_pkg::sat32(vva_pkg::sx66(prod_m_q[i]) >>> F);
			diff[i] = $signed({sb_m_q.a[i][31], sb_m_q.a[i]})
				- $signed({pr[i].val[31], pr[i].val});
			dsat[i] = vva_pkg::sat32({{33{diff[i][32]}}, diff[i]});
		end
		case (sb_m_q.op)
			vva_pkg::OP_PROJ: begin
				for (int i = 0; i < 3; i++) begin
					r_f[i] = pr[i].val;
					ovf_f  = ovf_f | pr[i].ovf;
				end
			end
			vva_pkg::OP_PERP: begin
				for (int i = 0; i < 3; i++) begin
					r_f[i] = dsat[i].val;
					ovf_f  = ovf_f | pr[i].ovf | dsat[i].ovf;
				end
			end
			default: begin
			end
		endcase
		// zero divisor clears the vector whatever was computed
		if (sb_m_q.divz)
			r_f = '0;
	end

	always_ff @(posedge clk) begin
		rx        <= $signed(r_f[0]);
		ry        <= $signed(r_f[1]);
		rz        <= $signed(r_f[2]);
		test_true <= sb_m_q.test;
		if (sb_m_q.divz)
			status <= vva_pkg::ST_DIVZ;
		else if (ovf_f)
			status <= vva_pkg::ST_SAT;
		else
			status <= vva_pkg::ST_OK;
	end

	// ------------------------------------------------------------------
	// valid bits, the only state that reset clears
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			for (int k = 0; k < NS; k++)
				v1_s[k] <= 1'b0;
			for (int k = 0; k < ND; k++)
				v2_s[k] <= 1'b0;
			v_m_q <= 1'b0;
			done  <= 1'b0;
		end else begin
			v_s1    <= start & ~busy;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v1_s[0] <= v_s3;
			for (int k = 1; k < NS; k++)
				v1_s[k] <= v1_s[k-1];
			v2_s[0] <= v1_s[NS-1];
			for (int k = 1; k < ND; k++)
				v2_s[k] <= v2_s[k-1];
			v_m_q   <= v2_s[ND-1];
			done    <= v_m_q;
		end
	end

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	`VVA_ASSERT_IMPL(a_latency, done, $past(start, vva_pkg::LATENCY), "result without request")
	`VVA_ASSERT_IMPL(a_divz_zero, done && status == vva_pkg::ST_DIVZ,
		rx == 0 && ry == 0 && rz == 0, "zero divisor result not cleared")
	`VVA_ASSERT_IMPL(a_test_ok, done && test_true, status == vva_pkg::ST_OK && rx == 0,
		"perpendicular test with bad status")
	`VVA_ASSERT(a_status_code, !done || status != 2'd3, "undefined status code")

endmodule

FILE: bench/testbench.sv
// self-checking bench for the three-component vector unit vec3_vector_alu
// holds its own bit-exact model of every operation and a scoreboard class
// depends on vva_pkg and the rtl under src
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [31:0] word_t;
	typedef logic signed [95:0] wide_t;
	typedef logic [67:0]        rad_t;

	localparam wide_t      WORD_MAX = 96'sd2147483647;
	localparam wide_t      WORD_MIN = -96'sd2147483648;

	typedef struct {
		word_t            x, y, z;
		logic             test;
		vva_pkg::status_t st;
	} vec_res_t;

	// scoreboard: works out the answer of each request and checks results in order
	class vec_scoreboard;
		vec_res_t pending[$];
		int       errors;

		function new();
			errors = 0;
		endfunction

		static function word_t clamp(input wide_t v, inout bit ovf);
			if (v > WORD_MAX) begin
				ovf = 1;
				return word_t'(WORD_MAX);
			end
			if (v < WORD_MIN) begin
				ovf = 1;
				return word_t'(WORD_MIN);
			end
			return word_t'(v);
		endfunction

		// exact product, sign extended
		static function wide_t mul(input word_t p, input word_t q);
			return wide_t'(p) * wide_t'(q);
		endfunction

		static function rad_t root(input rad_t n);
			rad_t res, bitpos;
			res = 0;
			bitpos = rad_t'(1) << 66;
			while (bitpos > n)
				bitpos >>= 2;
			while (bitpos != 0) begin
				if (n >= res + bitpos) begin
					n -= res + bitpos;
					res = (res >> 1) + bitpos;
				end else begin
					res >>= 1;
				end
				bitpos >>= 2;
			end
			return res;
		endfunction

		function vec_res_t predict(input logic [2:0] op, input word_t a[3], input word_t b[3]);
			vec_res_t r;
			bit ovf, divz;
			wide_t d, e, t, pr, sum;
			rad_t sq, len;
			word_t v[3];
			ovf = 0;
			divz = 0;
			v = '{0, 0, 0};
			r.test = 0;
			case (op)
				vva_pkg::OP_DOT: begin
					sum = mul(a[0], b[0]) + mul(a[1], b[1]) + mul(a[2], b[2]);
					v[0] = clamp(sum >>> vva_pkg::FRAC_BITS, ovf);
				end
				vva_pkg::OP_CROSS: begin
					v[0] = clamp((mul(a[1], b[2]) - mul(a[2], b[1])) >>> vva_pkg::FRAC_BITS,
						ovf);
					v[1] = clamp((mul(a[2], b[0]) - mul(a[0], b[2])) >>> vva_pkg::FRAC_BITS,
						ovf);
					v[2] = clamp((mul(a[0], b[1]) - mul(a[1], b[0])) >>> vva_pkg::FRAC_BITS,
						ovf);
				end
				vva_pkg::OP_PROJ, vva_pkg::OP_PERP: begin
					sum = mul(a[0], b[0]) + mul(a[1], b[1]) + mul(a[2], b[2]);
					d = wide_t'(clamp(sum >>> vva_pkg::FRAC_BITS, ovf));
					sum = mul(b[0], b[0]) + mul(b[1], b[1]) + mul(b[2], b[2]);
					e = wide_t'(clamp(sum >>> vva_pkg::FRAC_BITS, ovf));
					if (e <= 0) begin
						divz = 1;
					end else begin
						t = wide_t'(clamp((d <<< vva_pkg::FRAC_BITS) / e, ovf));
						for (int i = 0; i < 3; i++) begin
							pr = wide_t'(clamp((wide_t'(b[i]) * t) >>> vva_pkg::FRAC_BITS,
								ovf));
							v[i] = (op == vva_pkg::OP_PROJ) ? word_t'(pr)
								: clamp(wide_t'(a[i]) - pr, ovf);
						end
					end
				end
				vva_pkg::OP_LEN, vva_pkg::OP_NORM: begin
					sq = 0;
					for (int i = 0; i < 3; i++)
						sq += rad_t'(mul(a[i], a[i]));
					len = root(sq);
					if (op == vva_pkg::OP_LEN) begin
						v[0] = clamp(wide_t'(len), ovf);
					end else if (len == 0) begin
						divz = 1;
					end else begin
						for (int i = 0; i < 3; i++)
							v[i] = clamp((wide_t'(a[i]) <<< vva_pkg::FRAC_BITS)
								/ wide_t'(len), ovf);
					end
				end
				vva_pkg::OP_TEST: begin
					sum = mul(a[0], b[0]) + mul(a[1], b[1]) + mul(a[2], b[2]);
					r.test = (sum == 0);
				end
				default: ;
			endcase
			if (divz)
				v = '{0, 0, 0};
			r.x = v[0];
			r.y = v[1];
			r.z = v[2];
			r.st = divz ? vva_pkg::ST_DIVZ : (ovf ? vva_pkg::ST_SAT : vva_pkg::ST_OK);
			return r;
		endfunction

		function void note_request(input logic [2:0] op, input word_t a[3], input word_t b[3]);
			pending.push_back(predict(op, a, b));
		endfunction

		function void check_result(input word_t x, input word_t y, input word_t z,
			input logic test, input logic [1:0] st);
			vec_res_t w;
			if (pending.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
				return;
			end
			w = pending.pop_front();
			if (x !== w.x) begin
				$error("rx expected %0d actual %0d", w.x, x);
				errors++;
			end
			if (y !== w.y) begin
				$error("ry expected %0d actual %0d", w.y, y);
				errors++;
			end
			if (z !== w.z) begin
				$error("rz expected %0d actual %0d", w.z, z);
				errors++;
			end
			if (test !== w.test) begin
				$error("test_true expected %0b actual %0b", w.test, test);
				errors++;
			end
			if (st !== w.st) begin
				$error("status expected %0d actual %0d", w.st, st);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  opcode;
	word_t       ax, ay, az, bx, by, bz;
	logic        done;
	word_t       rx, ry, rz;
	logic        test_true;
	logic [1:0]  status;

	vec_scoreboard results = new();

	vec3_vector_alu i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .opcode(opcode),
		.ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz),
		.done(done), .rx(rx), .ry(ry), .rz(rz), .test_true(test_true), .status(status)
	);

	// 2 ns clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// results come at the edge that ends their strobe cycle and cannot be held off
	always @(posedge clk) begin
		if (arst_n && done)
			results.check_result(rx, ry, rz, test_true, status);
	end

	// hand one request over, holding start until the unit takes it
	task automatic issue(input logic [2:0] op, input word_t a[3], input word_t b[3]);
		start  <= 1'b1;
		opcode <= op;
		ax <= a[0]; ay <= a[1]; az <= a[2];
		bx <= b[0]; by <= b[1]; bz <= b[2];
		do @(posedge clk); while (busy);
		results.note_request(op, a, b);
	endtask

	// random gap after a request; with no gap start stays high for the next one
	task automatic pause_sender();
		int gap;
		gap = $urandom_range(0, 4);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// one random component, drawn from a mix of ranges so that small and huge values both show up
	function automatic word_t pick_word();
		case ($urandom_range(0, 5))
			0, 1: return word_t'($urandom);
			2, 3: return word_t'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
			4: return word_t'($signed($urandom_range(0, 32'h0000_0200)) - 32'sh0000_0100);
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7fff_ffff;
					1: return 32'sh8000_0000;
					2: return 32'sh0001_0000;
					default: return 32'sh0;
				endcase
			end
		endcase
	endfunction

	word_t va[3], vb[3];
	logic [2:0] op;

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		opcode = vva_pkg::OP_DOT;
		ax = 0; ay = 0; az = 0; bx = 0; by = 0; bz = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every operation at the extremes plus the zero-divisor and exact-zero cases
		va = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
		vb = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
		for (int k = 0; k < 8; k++) begin
			issue(k[2:0], va, vb);
			pause_sender();
		end
		va = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
		for (int k = 0; k < 8; k++)
			issue(k[2:0], va, va);
		// zero vector b for projection, zero vector a for normalising
		va = '{32'sh0003_0000, -32'sh0002_0000, 32'sh0000_8000};
		vb = '{0, 0, 0};
		issue(vva_pkg::OP_PROJ, va, vb);
		issue(vva_pkg::OP_PERP, va, vb);
		issue(vva_pkg::OP_NORM, vb, va);
		issue(vva_pkg::OP_LEN, vb, va);
		// tiny b whose square rounds to nothing
		vb = '{1, -1, 1};
		issue(vva_pkg::OP_PROJ, va, vb);
		// perpendicular pair and a near miss
		vb = '{32'sh0002_0000, 32'sh0003_0000, 0};
		issue(vva_pkg::OP_TEST, va, vb);
		vb = '{32'sh0002_0000, 32'sh0003_0000, 1};
		issue(vva_pkg::OP_TEST, va, vb);
		issue(vva_pkg::OP_CROSS, va, vb);

		// hold off until the pipe has drained completely
		start <= 1'b0;
		while (results.pending.size() != 0)
			@(posedge clk);
		@(posedge clk);

		// random part
		for (int n = 0; n < 1500; n++) begin
			op = 3'($urandom_range(0, 7));
			for (int i = 0; i < 3; i++) begin
				va[i] = pick_word();
				vb[i] = pick_word();
			end
			// a share of the perpendicular tests get a truly perpendicular b
			if (op == vva_pkg::OP_TEST && $urandom_range(0, 1)) begin
				vb[0] = -va[1];
				vb[1] = va[0];
				va[2] = 0;
			end
			// and some projections and normalisations get a zero divisor
			if ((op == vva_pkg::OP_PROJ || op == vva_pkg::OP_PERP)
				&& $urandom_range(0, 9) == 0)
				vb = '{0, 0, 0};
			if (op == vva_pkg::OP_NORM && $urandom_range(0, 9) == 0)
				va = '{0, 0, 0};
			issue(op, va, vb);
			pause_sender();
		end
		start <= 1'b0;

		while (results.pending.size() != 0)
			@(posedge clk);
		repeat (vva_pkg::LATENCY + 20) @(posedge clk);
		if (results.errors == 0 && results.pending.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// watchdog
	initial begin
		#2ms;
		$display("testbench: done, errors");
		$finish;
	end
endmodule
